@@ sv/twcd_pkg.sv @@
// Package: shared types, constants and codes for the trailing window counter delta block.
package twcd_pkg;

    localparam int RING_DEPTH_DEF = 64;
    localparam int TIME_W         = 32;
    localparam int READ_W         = 32;
    localparam int SPACING_W      = 16;
    localparam int WINDOW_W       = 20;
    localparam int CFG_DATA_W     = 20;
    localparam int CFG_IDX_W      = 1;

    localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd55;
    localparam logic [WINDOW_W-1:0]  WINDOW_RESET  = 20'd3600;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPACING = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_WINDOW  = 1'b1;

    typedef struct packed {
        logic [TIME_W-1:0] now_s;
        logic [READ_W-1:0] reading_milli;
    } in_t;

    typedef struct packed {
        logic [READ_W-1:0] window_usage_milli;
        logic              history_ready;
    } out_t;

    typedef struct packed {
        logic [TIME_W-1:0] sample_time;
        logic [READ_W-1:0] sample_reading;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic scan;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic skip_scan;
        logic scan_done;
        logic out_free;
    } status_t;

endpackage

@@ sv/twcd_ctrl.sv @@
// Controller: sequences accept, ring update, history scan and result hand-off.
module twcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  twcd_pkg::status_t status,
    output twcd_pkg::cmd_t    cmd,
    output twcd_pkg::state_t  state
);

    twcd_pkg::state_t state_reg;
    twcd_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= twcd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            twcd_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = twcd_pkg::ST_DECIDE;
                end
            end
            twcd_pkg::ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = status.skip_scan ? twcd_pkg::ST_EMIT : twcd_pkg::ST_SCAN;
            end
            twcd_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.scan_done)
                begin
                    state_next = twcd_pkg::ST_EMIT;
                end
            end
            twcd_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = twcd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = twcd_pkg::ST_IDLE;
            end
        endcase
    end

    assign state = state_reg;

endmodule

@@ sv/twcd_dp.sv @@
// Datapath: config registers, sample ring memory, scan pointers and output register.
module twcd_dp #(
    parameter int RING_DEPTH = twcd_pkg::RING_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  twcd_pkg::in_t                       in_data,
    output twcd_pkg::out_t                      out_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_we,
    input  logic [twcd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [twcd_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  twcd_pkg::cmd_t                      cmd,
    output twcd_pkg::status_t                   status
);

    localparam int PW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int DW = CW + 1;
    localparam logic [PW-1:0] LAST_IDX = PW'(RING_DEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(RING_DEPTH);
    localparam logic [DW-1:0] DEPTH_D  = DW'(RING_DEPTH);

    logic [twcd_pkg::SPACING_W-1:0] spacing_reg;
    logic [twcd_pkg::WINDOW_W-1:0]  window_reg;

    twcd_pkg::in_t   in_reg;
    twcd_pkg::entry_t ring_mem [RING_DEPTH];
    twcd_pkg::entry_t rdata_reg;

    logic [PW-1:0]   wp_reg;
    logic [CW-1:0]   cnt_reg;
    logic [twcd_pkg::TIME_W-1:0] last_kept_reg;

    logic [PW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   issued_reg;
    logic [CW-1:0]   checked_reg;
    logic            dvalid_reg;
    logic            hist_ok_reg;
    logic [twcd_pkg::READ_W-1:0] ref_reading_reg;

    twcd_pkg::out_t  out_reg;
    logic            out_valid_reg;

    logic                        nonzero;
    logic [twcd_pkg::TIME_W-1:0] elapsed;
    logic                        keep;
    logic [PW-1:0]               wp_next;
    logic [CW-1:0]               cnt_next;
    logic [DW-1:0]               diff;
    logic [PW-1:0]               oldest;
    logic                        issue;
    logic                        qualify;
    logic                        out_free;
    logic [twcd_pkg::READ_W-1:0] usage;

    // Ring update decision
    always_comb
    begin
        nonzero  = (in_reg.reading_milli != '0);
        elapsed  = (in_reg.now_s >= last_kept_reg) ? (in_reg.now_s - last_kept_reg) : '0;
        keep     = nonzero && ((cnt_reg == '0) ||
                   (elapsed >= twcd_pkg::TIME_W'(spacing_reg)));
        wp_next  = keep ? ((wp_reg == LAST_IDX) ? '0 : (wp_reg + PW'(1))) : wp_reg;
        cnt_next = (keep && (cnt_reg != DEPTH_C)) ? (cnt_reg + CW'(1)) : cnt_reg;
        diff     = DW'(wp_next) + DEPTH_D - DW'(cnt_next);
        oldest   = (diff >= DEPTH_D) ? PW'(diff - DEPTH_D) : PW'(diff);
    end

    // Scan check on the entry read last cycle
    always_comb
    begin
        issue   = cmd.scan && (issued_reg != cnt_reg);
        qualify = (rdata_reg.sample_time <= in_reg.now_s) &&
                  ((in_reg.now_s - rdata_reg.sample_time) >=
                   twcd_pkg::TIME_W'(window_reg));
        out_free = !out_valid_reg || out_ready;
        usage    = (hist_ok_reg && (in_reg.reading_milli > ref_reading_reg)) ?
                   (in_reg.reading_milli - ref_reading_reg) : '0;
    end

    assign status.skip_scan = !nonzero || (cnt_next < CW'(2));
    assign status.scan_done = dvalid_reg &&
                              (!qualify || ((checked_reg + CW'(1)) == cnt_reg));
    assign status.out_free  = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg <= twcd_pkg::SPACING_RESET;
            window_reg  <= twcd_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                twcd_pkg::CFG_IDX_SPACING: spacing_reg <= cfg_data[twcd_pkg::SPACING_W-1:0];
                twcd_pkg::CFG_IDX_WINDOW:  window_reg  <= cfg_data;
                default:                   ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            cnt_reg       <= '0;
            last_kept_reg <= '0;
            dvalid_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.decide && keep)
            begin
                wp_reg        <= wp_next;
                cnt_reg       <= cnt_next;
                last_kept_reg <= in_reg.now_s;
            end
            dvalid_reg <= issue;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            issued_reg  <= '0;
            checked_reg <= '0;
        end
        else if (cmd.decide)
        begin
            rd_ptr_reg  <= oldest;
            issued_reg  <= '0;
            checked_reg <= '0;
        end
        else
        begin
            if (issue)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_IDX) ? '0 : (rd_ptr_reg + PW'(1));
                issued_reg <= issued_reg + CW'(1);
            end
            if (cmd.scan && dvalid_reg)
            begin
                checked_reg <= checked_reg + CW'(1);
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= in_data;
        end
        if (cmd.decide)
        begin
            hist_ok_reg <= !status.skip_scan;
        end
        if (cmd.scan && dvalid_reg && ((checked_reg == '0) || qualify))
        begin
            ref_reading_reg <= rdata_reg.sample_reading;
        end
        if (cmd.emit)
        begin
            out_reg.window_usage_milli <= usage;
            out_reg.history_ready      <= hist_ok_reg;
        end
    end

    // Sample ring
    always_ff @(posedge clk)
    begin
        if (cmd.decide && keep)
        begin
            ring_mem[wp_reg] <= '{sample_time: in_reg.now_s,
                                  sample_reading: in_reg.reading_milli};
        end
        if (issue)
        begin
            rdata_reg <= ring_mem[rd_ptr_reg];
        end
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

@@ sv/trailing_window_counter_delta.sv @@
// Top level: trailing window counter delta with controller, datapath and checks.
// Each transaction is taken in ST_IDLE, then ST_DECIDE updates the sample ring;
// for a nonzero reading with two or more samples kept, the stored history is scanned
// from the oldest entry through the single read port of the ring memory, one entry
// per cycle through a registered read, stopping at the first entry younger than the
// window or at the newest kept entry. At most RING_DEPTH entries are scanned. The
// result is held in an output register, so a waiting result does not block the
// next input transaction. The ring needs no clearing after reset.
module trailing_window_counter_delta #(
    parameter int RING_DEPTH = twcd_pkg::RING_DEPTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  twcd_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output twcd_pkg::out_t                  out_data,
    input  logic                            cfg_we,
    input  logic [twcd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [twcd_pkg::CFG_DATA_W-1:0] cfg_data
);

    twcd_pkg::cmd_t    cmd;
    twcd_pkg::status_t status;
    twcd_pkg::state_t  state;

    twcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    twcd_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

    a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state == twcd_pkg::ST_DECIDE))
        else $error("accepted transaction did not move to ring update");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state == twcd_pkg::ST_EMIT && !out_valid) |=>
        (out_valid && state == twcd_pkg::ST_IDLE))
        else $error("result not delivered to free output register");

    a_no_history_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.history_ready) |-> (out_data.window_usage_milli == '0))
        else $error("nonzero usage without history");

endmodule

@@ test/trailing_window_counter_delta_tb.sv @@
// Self-checking testbench for the trailing window counter delta block.
module trailing_window_counter_delta_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = twcd_pkg::RING_DEPTH_DEF;
    localparam int LONG_HOLD = 400;

    class window_usage_model;
        logic [twcd_pkg::TIME_W-1:0]    kept_time [DEPTH];
        logic [twcd_pkg::READ_W-1:0]    kept_reading [DEPTH];
        int                             wr_ptr;
        int                             kept;
        logic [twcd_pkg::TIME_W-1:0]    last_kept;
        logic [twcd_pkg::SPACING_W-1:0] spacing;
        logic [twcd_pkg::WINDOW_W-1:0]  window;
        twcd_pkg::out_t                 usage_due [$];
        int                             errors;

        function new();
            wr_ptr    = 0;
            kept      = 0;
            last_kept = '0;
            spacing   = twcd_pkg::SPACING_RESET;
            window    = twcd_pkg::WINDOW_RESET;
            errors    = 0;
        endfunction

        function void set_reg(input logic [twcd_pkg::CFG_IDX_W-1:0] idx,
                              input logic [twcd_pkg::CFG_DATA_W-1:0] value);
            if (idx == twcd_pkg::CFG_IDX_SPACING)
                spacing = value[twcd_pkg::SPACING_W-1:0];
            else if (idx == twcd_pkg::CFG_IDX_WINDOW)
                window = value[twcd_pkg::WINDOW_W-1:0];
        endfunction

        function void take_reading(input twcd_pkg::in_t x);
            twcd_pkg::out_t              r;
            logic [twcd_pkg::TIME_W-1:0] elapsed;
            logic [twcd_pkg::TIME_W-1:0] t;
            int                          idx;
            int                          ref_idx;
            r = '0;
            if (x.reading_milli != '0)
            begin
                elapsed = (x.now_s >= last_kept) ? x.now_s - last_kept : '0;
                if (kept == 0 || elapsed >= spacing)
                begin
                    kept_time[wr_ptr]    = x.now_s;
                    kept_reading[wr_ptr] = x.reading_milli;
                    wr_ptr               = (wr_ptr + 1) % DEPTH;
                    if (kept < DEPTH)
                        kept++;
                    last_kept = x.now_s;
                end
                if (kept >= 2)
                begin
                    // newest entry of the leading run that is at least a window old, else the oldest entry
                    idx     = (wr_ptr + DEPTH - kept) % DEPTH;
                    ref_idx = idx;
                    for (int k = 0; k < kept; k++)
                    begin
                        t = kept_time[idx];
                        if (t <= x.now_s && (x.now_s - t) >= window)
                            ref_idx = idx;
                        else
                            break;
                        idx = (idx + 1) % DEPTH;
                    end
                    if (x.reading_milli > kept_reading[ref_idx])
                        r.window_usage_milli = x.reading_milli - kept_reading[ref_idx];
                    r.history_ready = 1'b1;
                end
            end
            usage_due.push_back(r);
        endfunction

        task flag_mismatch(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task check_usage(input twcd_pkg::out_t got);
            twcd_pkg::out_t want;
            if (usage_due.size() == 0)
            begin
                flag_mismatch("result transaction with nothing expected");
                return;
            end
            want = usage_due.pop_front();
            if (got.window_usage_milli !== want.window_usage_milli)
                flag_mismatch($sformatf("window_usage_milli %0d, expected %0d",
                                        got.window_usage_milli, want.window_usage_milli));
            if (got.history_ready !== want.history_ready)
                flag_mismatch($sformatf("history_ready %0b, expected %0b",
                                        got.history_ready, want.history_ready));
        endtask
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    twcd_pkg::in_t                   in_data;
    logic                            out_valid;
    logic                            out_ready;
    twcd_pkg::out_t                  out_data;
    logic                            cfg_we;
    logic [twcd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [twcd_pkg::CFG_DATA_W-1:0] cfg_data;

    window_usage_model               usage_board;
    bit                              quiet;
    bit                              long_hold;
    logic [twcd_pkg::TIME_W-1:0]     wall_s;
    logic [twcd_pkg::READ_W-1:0]     meter;
    int unsigned                     gap;
    int unsigned                     span;

    trailing_window_counter_delta u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12_000_000);
        $display("trailing_window_counter_delta_tb failed");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && usage_board != null)
        begin
            if (out_valid && out_ready)
                usage_board.check_usage(out_data);
            if (in_valid && in_ready)
                usage_board.take_reading(in_data);
        end
    end

    // result side: short random stalls, plus one long hold to back up the input
    initial
    begin
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
                long_hold = 1'b0;
                out_ready <= 1'b1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic offer(input logic [twcd_pkg::TIME_W-1:0] at_s,
                         input logic [twcd_pkg::READ_W-1:0] milli);
        twcd_pkg::in_t item;
        item.now_s         = at_s;
        item.reading_milli = milli;
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [twcd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [twcd_pkg::CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        usage_board.set_reg(idx, value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (usage_board.usage_due.size() != 0) @(negedge clk);
    endtask

    task automatic run_phase(input int items, input int unsigned step_max);
        int                          pick;
        logic [twcd_pkg::READ_W-1:0] milli;
        for (int i = 0; i < items; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 2)
                wall_s = $urandom();
            else if (pick < 5)
                wall_s = wall_s - $urandom_range(1, 300);
            else
                wall_s = wall_s + $urandom_range(0, step_max);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                meter = $urandom();
            else if (pick < 7)
                meter = meter - $urandom_range(0, 5000);
            else
                meter = meter + $urandom_range(0, 4000);
            milli = (pick >= 93) ? '0 : meter;
            offer(wall_s, milli);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        quiet     = 1'b0;
        long_hold = 1'b0;
        wall_s    = '0;
        meter     = '0;
        usage_board = new();
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // reset settings: empty ring, sample at time zero, clamp, time going back
        offer(32'd0, 32'd0);
        offer(32'd0, 32'd5);
        offer(32'd10, 32'd7);
        offer(32'd55, 32'd100);
        offer(32'd60, 32'd3);
        offer(32'd70, 32'd0);
        offer(32'd30, 32'd200);
        offer(32'd3655, 32'd900);
        offer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(32'd100, 32'd1000);
        offer(32'h8000_0000, 32'h8000_0000);
        settle();

        // zero spacing and zero window; a future entry stops the scan
        write_reg(twcd_pkg::CFG_IDX_SPACING, '0);
        write_reg(twcd_pkg::CFG_IDX_WINDOW, '0);
        offer(32'h8000_0000, 32'd1);
        offer(32'h8000_0000, 32'd2000);
        settle();

        // top of both ranges, spacing field masked
        write_reg(twcd_pkg::CFG_IDX_SPACING, '1);
        write_reg(twcd_pkg::CFG_IDX_WINDOW, '1);
        offer(32'h8001_0000, 32'd5000);
        offer(32'h8001_FFFE, 32'd6000);
        settle();

        wall_s = 32'h8002_0000;
        meter  = 32'd10000;
        for (int p = 0; p < 8; p++)
        begin
            case (p)
                1:
                begin
                    gap  = 0;
                    span = 0;
                end
                2:
                begin
                    gap  = 65535;
                    span = 1048575;
                end
                default:
                begin
                    gap  = $urandom_range(1, 150);
                    span = $urandom_range(0, 64 * gap + 100);
                end
            endcase
            write_reg(twcd_pkg::CFG_IDX_SPACING, twcd_pkg::CFG_DATA_W'(gap));
            write_reg(twcd_pkg::CFG_IDX_WINDOW, twcd_pkg::CFG_DATA_W'(span));
            quiet = (p == 7) || ($urandom_range(0, 3) == 0);
            if (p == 3)
                long_hold = 1'b1;
            run_phase(120, 2 * gap + 3);
            settle();
        end

        repeat (100) @(negedge clk);
        if (usage_board.errors == 0)
            $display("trailing_window_counter_delta_tb passed");
        else
            $display("trailing_window_counter_delta_tb failed");
        $finish;
    end

endmodule
